/* rtl/core/octnb_pkg.sv */
package octnb_pkg;

  // coordinate and id geometry
  localparam int unsigned COORD_DIGITS = 20;
  localparam int unsigned ROOT_BITS    = 21;
  localparam int unsigned ID_W         = 64;
  localparam int unsigned AXES         = 3;

  // marker pattern that sits above the coordinate triplets
  localparam logic [ID_W-1:0] MARKER = ID_W'(10);
  localparam logic [ID_W-1:0] MARKER_MAX = ID_W'(10);

  // deepest level: the remainder above the triplets is at most three bits wide
  localparam int unsigned MAX_LEVEL = (ID_W - 1 - ROOT_BITS) / 3;
  localparam int unsigned LEVEL_W   = $clog2(MAX_LEVEL + 1);
  localparam int unsigned OUT_LEVEL_W = 4;
  localparam int unsigned OUT_LEVEL_SAT = (1 << OUT_LEVEL_W) - 1;

  localparam int unsigned BLOCKS_W = 8;
  localparam int unsigned ACTION_W = 3;

  // stream packing
  localparam int unsigned IN_FIELDS_W  = ID_W + ACTION_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = ID_W + 1 + OUT_LEVEL_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // register file
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BLOCKS_X = 2'd0,
    REG_BLOCKS_Y = 2'd1,
    REG_BLOCKS_Z = 2'd2
  } reg_idx_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_EAST   = 3'd0,
    ACT_WEST   = 3'd1,
    ACT_NORTH  = 3'd2,
    ACT_SOUTH  = 3'd3,
    ACT_TOP    = 3'd4,
    ACT_BOTTOM = 3'd5
  } action_e;

  typedef logic [COORD_DIGITS-1:0] coord_t;

  // pull one axis's coordinate out of the interleaved word
  function automatic coord_t gather_axis(input logic [ID_W-1:0] v, input int unsigned axis);
    coord_t c;
    c = '0;
    for (int unsigned i = 0; i < COORD_DIGITS; i++) begin
      c[i] = v[3*i + axis];
    end
    return c;
  endfunction

  // put one axis's coordinate back into the interleaved word
  function automatic logic [ID_W-1:0] scatter_axis(input logic [ID_W-1:0] v,
                                                    input int unsigned axis,
                                                    input coord_t c);
    logic [ID_W-1:0] r;
    r = v;
    for (int unsigned i = 0; i < COORD_DIGITS; i++) begin
      r[3*i + axis] = c[i];
    end
    return r;
  endfunction

endpackage

/* rtl/core/octree_morton_neighbor_id.sv */
// octree face-neighbor lookup on morton-coded node ids
//
// input stream (s_axis_*): one beat per query, tdata = node_id then action.
//   action selects the face: east/west (x), north/south (y), top/bottom (z).
// output stream (m_axis_*): one beat per query, same order, tdata =
//   neighbor_id, is_domain_edge, node_level.
// config (apb): blocks_x at 0x0, blocks_y at 0x4, blocks_z at 0x8, low 8 bits
//   used, readable, reset value 1. write only while no query is in flight.
//
// timing: a beat taken is computed from the input register and is loaded
//   into the output register once that register can load, then offered.
//   one query per cycle sustained while m_axis_tready stays high; the lookup
//   itself (level decode, marker strip, coordinate step, marker restore) sits
//   in a single stage between the two registers.
// back-pressure: the input stage and the output register each hold one beat;
//   when m_axis_tready is low both fill, then s_axis_tready drops. nothing is
//   dropped or duplicated.
// reset: rst_ni clears both valid flags and sets the block counts to 1.
module octree_morton_neighbor_id (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // query stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [63:0] node_id, [66:64] action, [71:67] zero
  input  logic [octnb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [63:0] neighbor_id, [64] is_domain_edge, [68:65] node_level, [71:69] zero
  output logic [octnb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [octnb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [octnb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [octnb_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import octnb_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [BLOCKS_W-1:0] blocks_x_q, blocks_y_q, blocks_z_q;
  logic                cfg_we;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_x_q <= BLOCKS_W'(1);
      blocks_y_q <= BLOCKS_W'(1);
      blocks_z_q <= BLOCKS_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_BLOCKS_X: blocks_x_q <= pwdata[BLOCKS_W-1:0];
        REG_BLOCKS_Y: blocks_y_q <= pwdata[BLOCKS_W-1:0];
        REG_BLOCKS_Z: blocks_z_q <= pwdata[BLOCKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_BLOCKS_X: prdata = APB_DATA_W'(blocks_x_q);
      REG_BLOCKS_Y: prdata = APB_DATA_W'(blocks_y_q);
      REG_BLOCKS_Z: prdata = APB_DATA_W'(blocks_z_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  logic                s1_valid_q;
  logic [ID_W-1:0]     id_q;
  logic [ACTION_W-1:0] act_q;
  logic                out_valid_q;
  logic                out_en;

  // output register can load when empty or being drained this cycle
  assign out_en        = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = ~s1_valid_q | out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      id_q  <= s_axis_tdata[ID_W-1:0];
      act_q <= s_axis_tdata[ID_W +: ACTION_W];
    end
  end

  // ---------------------------------------------------------------- lookup
  logic [LEVEL_W-1:0] level;
  logic [ID_W-1:0]    marker;
  logic [ID_W-1:0]    body;
  logic [1:0]         axis;
  logic               down;
  logic               act_ok;
  logic [BLOCKS_W-1:0] blocks;
  coord_t             coord, coord_nb, coord_last;
  logic [ID_W-1:0]    neighbor;
  logic               edge_hit;
  logic [OUT_LEVEL_W-1:0] level_out;

  // every level test is independent; the shallowest passing one wins
  always_comb begin
    level  = LEVEL_W'(MAX_LEVEL);
    marker = MARKER << (ROOT_BITS + 3*MAX_LEVEL);
    for (int k = MAX_LEVEL; k >= 0; k--) begin
      if ((id_q >> (ROOT_BITS + 3*k)) <= MARKER_MAX) begin
        level  = LEVEL_W'(k);
        marker = MARKER << (ROOT_BITS + 3*k);
      end
    end
  end

  assign body = id_q - marker;

  always_comb begin
    act_ok = 1'b1;
    axis   = 2'd0;
    down   = 1'b0;
    unique case (act_q)
      ACT_EAST:   begin axis = 2'd0; down = 1'b0; end
      ACT_WEST:   begin axis = 2'd0; down = 1'b1; end
      ACT_NORTH:  begin axis = 2'd1; down = 1'b0; end
      ACT_SOUTH:  begin axis = 2'd1; down = 1'b1; end
      ACT_TOP:    begin axis = 2'd2; down = 1'b0; end
      ACT_BOTTOM: begin axis = 2'd2; down = 1'b1; end
      default:    act_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (axis)
      2'd0:    begin coord = gather_axis(body, 0); blocks = blocks_x_q; end
      2'd1:    begin coord = gather_axis(body, 1); blocks = blocks_y_q; end
      default: begin coord = gather_axis(body, 2); blocks = blocks_z_q; end
    endcase
  end

  // far face of the domain, wrapped to the coordinate width
  assign coord_last = (coord_t'(blocks) << level) - coord_t'(1);
  assign coord_nb   = down ? (coord - coord_t'(1)) : (coord + coord_t'(1));

  always_comb begin
    neighbor = id_q;
    edge_hit = 1'b0;
    if (act_ok) begin
      edge_hit = down ? (coord == '0) : (coord == coord_last);
      case (axis)
        2'd0:    neighbor = scatter_axis(body, 0, coord_nb) + marker;
        2'd1:    neighbor = scatter_axis(body, 1, coord_nb) + marker;
        default: neighbor = scatter_axis(body, 2, coord_nb) + marker;
      endcase
    end
  end

  assign level_out = (32'(level) > OUT_LEVEL_SAT) ? OUT_LEVEL_W'(OUT_LEVEL_SAT)
                                                  : OUT_LEVEL_W'(level);

  // ---------------------------------------------------------------- result register
  logic [ID_W-1:0]        out_id_q;
  logic                   out_edge_q;
  logic [OUT_LEVEL_W-1:0] out_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s1_valid_q) begin
      out_id_q    <= neighbor;
      out_edge_q  <= edge_hit;
      out_level_q <= level_out;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_level_q, out_edge_q, out_id_q};

  // ---------------------------------------------------------------- checks
  // input side only stalls when both stages hold a beat and the sink is stalled
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while a stage was free");

  // a beat in the input stage moves to the output register when it can load
  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_en) |=> m_axis_tvalid)
    else $error("computed beat lost");

  // decoded level never exceeds the deepest level of the id format
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(out_level_q) <= MAX_LEVEL))
    else $error("node level out of range");

endmodule

/* tb/octree_morton_neighbor_id_tb.sv */
module octree_morton_neighbor_id_tb;

  import octnb_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RST_CYCLES   = 7;
  // quiet cycles tolerated before the run is called hung; the long
  // receiver hold and the idle pauses between phases stay well below
  localparam int unsigned QUIET_LIMIT  = 500;
  localparam int unsigned HOLD_CYCLES  = 64;
  // one register stage in front and one behind
  localparam int unsigned DRAIN_CYCLES = 4;
  // deepest level whose 1010 marker still fits in the 64-bit id
  localparam int unsigned TOP_LEVEL    = (ID_W - 4 - ROOT_BITS) / AXES;
  localparam int unsigned ROOT_DIGITS  = ROOT_BITS / AXES;

  // face codes the block must pass through untouched
  localparam logic [ACTION_W-1:0] ACT_RSVD_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]        nid;
    logic                   dom_edge;
    logic [OUT_LEVEL_W-1:0] lvl;
  } nbr_result_t;

  // directed query; the result is typed in only when known is set
  typedef struct {
    logic [ID_W-1:0]     id;
    logic [ACTION_W-1:0] act;
    bit                  known;
    nbr_result_t         res;
  } probe_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [63:0] node_id, [66:64] action, [71:67] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [63:0] neighbor_id, [64] is_domain_edge, [68:65] node_level, [71:69] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // local copy of the block counts, changed only while the block is idle
  logic [BLOCKS_W-1:0] blocks_cfg [AXES];

  nbr_result_t pending_nbr_q [$];
  probe_row_t  probe_rows [$];

  int unsigned err_cnt      = 0;
  int unsigned quiet_cycles = 0;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  bit          press_on     = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned hold_left    = 0;

  octree_morton_neighbor_id DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // place a coordinate's bits on one axis lane of the interleaved word
  function automatic logic [ID_W-1:0] spread_coord(input coord_t c, input int unsigned ax);
    logic [ID_W-1:0] r;
    r = '0;
    for (int unsigned i = 0; i < COORD_DIGITS; i++) begin
      r[AXES*i + ax] = c[i];
    end
    return r;
  endfunction

  // expected neighbor lookup for one query under the current block counts
  function automatic nbr_result_t predict_neighbor(input logic [ID_W-1:0] id,
                                                   input logic [ACTION_W-1:0] act);
    nbr_result_t     res;
    logic [ID_W-1:0] w;
    logic [ID_W-1:0] marker;
    logic [ID_W-1:0] body;
    logic [ID_W-1:0] lane;
    coord_t          c;
    coord_t          step;
    coord_t          last;
    int unsigned     lvl;
    int unsigned     ax;
    bit              down;
    bit              valid_face;
    w   = id >> ROOT_BITS;
    lvl = 0;
    // strip triplets until only the marker (or less) is left
    while (w > 64'd10) begin
      w = w >> AXES;
      lvl++;
    end
    marker = (ROOT_BITS + AXES*lvl < ID_W) ? (MARKER << (ROOT_BITS + AXES*lvl)) : '0;
    body   = id - marker;
    res.nid      = id;
    res.dom_edge = 1'b0;
    res.lvl      = (lvl > OUT_LEVEL_SAT) ? OUT_LEVEL_W'(OUT_LEVEL_SAT) : OUT_LEVEL_W'(lvl);
    valid_face = 1'b1;
    down       = 1'b0;
    ax         = 0;
    case (act)
      ACT_EAST:   ax = 0;
      ACT_WEST:   begin ax = 0; down = 1'b1; end
      ACT_NORTH:  ax = 1;
      ACT_SOUTH:  begin ax = 1; down = 1'b1; end
      ACT_TOP:    ax = 2;
      ACT_BOTTOM: begin ax = 2; down = 1'b1; end
      default:    valid_face = 1'b0;
    endcase
    if (valid_face) begin
      c = '0;
      for (int unsigned i = 0; i < COORD_DIGITS; i++) begin
        c[i] = body[AXES*i + ax];
      end
      if (down) begin
        res.dom_edge = (c == '0);
        step = c - 1'b1;
      end else begin
        last = coord_t'(({{(ID_W-BLOCKS_W){1'b0}}, blocks_cfg[ax]} << lvl) - 64'd1);
        res.dom_edge = (c == last);
        step = c + 1'b1;
      end
      lane    = spread_coord('1, ax);
      res.nid = ((body & ~lane) | spread_coord(step, ax)) + marker;
    end
    return res;
  endfunction

  // coordinate biased toward the domain faces and the wrap point
  function automatic coord_t pick_coord(input int unsigned lvl, input logic [BLOCKS_W-1:0] blk);
    coord_t      span;
    coord_t      last;
    int unsigned wbits;
    wbits = (lvl + ROOT_DIGITS > COORD_DIGITS) ? COORD_DIGITS : lvl + ROOT_DIGITS;
    span  = coord_t'((64'd1 << wbits) - 64'd1);
    last  = coord_t'(({{(ID_W-BLOCKS_W){1'b0}}, blk} << lvl) - 64'd1);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return last & span;
      2:       return (last - 1'b1) & span;
      3:       return (last + 1'b1) & span;
      4:       return span;
      default: return coord_t'($urandom) & span;
    endcase
  endfunction

  // mostly well-formed ids at random levels, the rest broken or raw noise
  function automatic logic [ID_W-1:0] gen_node_id();
    logic [ID_W-1:0] id;
    int unsigned     lvl;
    int unsigned     kind;
    kind = $urandom_range(0, 99);
    lvl  = $urandom_range(0, TOP_LEVEL);
    id = spread_coord(pick_coord(lvl, blocks_cfg[0]), 0)
       | spread_coord(pick_coord(lvl, blocks_cfg[1]), 1)
       | spread_coord(pick_coord(lvl, blocks_cfg[2]), 2)
       | (MARKER << (ROOT_BITS + AXES*lvl));
    if (kind < 78) begin
      return id;
    end else if (kind < 86) begin
      // one flipped bit in the marker or level region
      return id ^ (64'd1 << $urandom_range(ROOT_BITS, ID_W-1));
    end else if (kind < 95) begin
      return {$urandom, $urandom};
    end else begin
      return {32'd0, $urandom} >> $urandom_range(0, 31);
    end
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action();
    if ($urandom_range(0, 99) < 93) begin
      return ACTION_W'($urandom_range(ACT_EAST, ACT_BOTTOM));
    end else begin
      return ACTION_W'($urandom_range(ACT_RSVD_6, ACT_RSVD_7));
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                 input logic [ID_W-1:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  // compare one result beat with the oldest pending lookup
  task automatic check_result(input logic [OUT_DATA_W-1:0] d);
    nbr_result_t want;
    if (pending_nbr_q.size() == 0) begin
      report_mismatch("result beat with no query pending", d[ID_W-1:0], '0);
      return;
    end
    want = pending_nbr_q.pop_front();
    if (d[ID_W-1:0] !== want.nid) begin
      report_mismatch("neighbor_id", d[ID_W-1:0], want.nid);
    end
    if (d[ID_W] !== want.dom_edge) begin
      report_mismatch("is_domain_edge", ID_W'(d[ID_W]), ID_W'(want.dom_edge));
    end
    if (d[ID_W+1 +: OUT_LEVEL_W] !== want.lvl) begin
      report_mismatch("node_level", ID_W'(d[ID_W+1 +: OUT_LEVEL_W]), ID_W'(want.lvl));
    end
  endtask

  // result side: checks every accepted beat, stalls at random, and once
  // holds tready low for a long stretch so the block backs up to its input
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata);
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (press_on && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // watchdog: counts cycles in which neither stream moves a beat
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one query, with random sender gaps, and record its lookup on accept
  task automatic send_query(input logic [ID_W-1:0] id, input logic [ACTION_W-1:0] act,
                            input nbr_result_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({act, id});
    do @(posedge clk_i); while (!s_axis_tready);
    pending_nbr_q.push_back(want);
  endtask

  // drop valid and let every outstanding lookup come back
  task automatic drain_queries();
    s_axis_tvalid <= 1'b0;
    while (pending_nbr_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_blocks(input reg_idx_e idx, input logic [BLOCKS_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    // upper bits are don't-care for an 8-bit register
    pwdata  <= {24'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    blocks_cfg[idx] = val;
  endtask

  // one setting of the block counts and one idling pattern
  task automatic run_phase(input logic [BLOCKS_W-1:0] bx, input logic [BLOCKS_W-1:0] by,
                           input logic [BLOCKS_W-1:0] bz, input int txp, input int rxp,
                           input bit press, input int n_items);
    logic [ID_W-1:0]     id;
    logic [ACTION_W-1:0] act;
    drain_queries();
    write_blocks(REG_BLOCKS_X, bx);
    write_blocks(REG_BLOCKS_Y, by);
    write_blocks(REG_BLOCKS_Z, bz);
    tx_idle_pct  = txp;
    rx_stall_pct = rxp;
    press_on     = press;
    repeat (n_items) begin
      id  = gen_node_id();
      act = pick_action();
      send_query(id, act, predict_neighbor(id, act));
    end
  endtask

  initial begin
    logic [ID_W-1:0]     id;
    logic [ACTION_W-1:0] act;

    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_ni        <= 1'b0;
    for (int a = 0; a < AXES; a++) blocks_cfg[a] = 8'd1;

    // directed queries, all at the reset block counts of one
    // root node at level zero: every face sits on the domain boundary
    probe_rows.push_back('{64'h0000_0000_0140_0000, ACT_EAST, 1'b1,
                           '{64'h0000_0000_0140_0001, 1'b1, 4'd0}});
    probe_rows.push_back('{64'h0000_0000_0140_0000, ACT_WEST, 1'b0, '0});
    probe_rows.push_back('{64'h0000_0000_0140_0000, ACT_NORTH, 1'b1,
                           '{64'h0000_0000_0140_0002, 1'b1, 4'd0}});
    probe_rows.push_back('{64'h0000_0000_0140_0000, ACT_SOUTH, 1'b0, '0});
    probe_rows.push_back('{64'h0000_0000_0140_0000, ACT_TOP, 1'b1,
                           '{64'h0000_0000_0140_0004, 1'b1, 4'd0}});
    probe_rows.push_back('{64'h0000_0000_0140_0000, ACT_BOTTOM, 1'b0, '0});
    // unused face codes pass the id through with no edge
    probe_rows.push_back('{64'h0000_0000_0140_0000, ACT_RSVD_6, 1'b1,
                           '{64'h0000_0000_0140_0000, 1'b0, 4'd0}});
    probe_rows.push_back('{64'h0000_0000_0140_0000, ACT_RSVD_7, 1'b1,
                           '{64'h0000_0000_0140_0000, 1'b0, 4'd0}});
    // all-ones id decodes to the deepest level
    probe_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, ACT_RSVD_7, 1'b1,
                           '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 4'd14}});
    probe_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, ACT_EAST, 1'b0, '0});
    // zero id has no marker at all
    probe_rows.push_back('{64'h0, ACT_RSVD_6, 1'b1, '{64'h0, 1'b0, 4'd0}});
    probe_rows.push_back('{64'h0, ACT_WEST, 1'b0, '0});
    // level 13: steps past all-ones or below zero coordinates wrap around 20 bits
    probe_rows.push_back('{64'hAFFF_FFFF_FFFF_FFFF, ACT_EAST, 1'b0, '0});
    probe_rows.push_back('{64'hAFFF_FFFF_FFFF_FFFF, ACT_BOTTOM, 1'b0, '0});
    probe_rows.push_back('{64'hA000_0000_0000_0000, ACT_SOUTH, 1'b0, '0});
    probe_rows.push_back('{64'hA000_0000_0000_0000 | spread_coord(20'h01FFF, 0),
                           ACT_EAST, 1'b0, '0});
    // level one, x = 1: the last cell of a single block
    probe_rows.push_back('{64'h0000_0000_0A00_0001, ACT_EAST, 1'b1,
                           '{64'h0000_0000_0A00_0008, 1'b1, 4'd1}});
    probe_rows.push_back('{64'h0000_0000_0A00_0001, ACT_WEST, 1'b1,
                           '{64'h0000_0000_0A00_0000, 1'b0, 4'd1}});
    // coordinates beyond the domain at level zero
    probe_rows.push_back('{64'h0000_0000_015F_FFFF, ACT_NORTH, 1'b0, '0});
    probe_rows.push_back('{64'h0000_0000_015F_FFFF, ACT_TOP, 1'b0, '0});
    // malformed ids
    probe_rows.push_back('{64'h8000_0000_0000_0000, ACT_TOP, 1'b0, '0});
    probe_rows.push_back('{64'h5555_5555_5555_5555, ACT_SOUTH, 1'b0, '0});
    probe_rows.push_back('{64'h0000_0000_001F_FFFF, ACT_EAST, 1'b0, '0});

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 0: reset counts, directed table then random, no idling
    foreach (probe_rows[i]) begin
      send_query(probe_rows[i].id, probe_rows[i].act,
                 probe_rows[i].known ? probe_rows[i].res
                                     : predict_neighbor(probe_rows[i].id, probe_rows[i].act));
    end
    repeat (60) begin
      id  = gen_node_id();
      act = pick_action();
      send_query(id, act, predict_neighbor(id, act));
    end

    // counts of 128 on every axis, sender idling
    run_phase(8'd128, 8'd128, 8'd128, 63, 0, 1'b0, 120);
    // mixed counts, receiver stalling
    run_phase(8'd1, 8'd128, 8'd5, 0, 63, 1'b0, 120);
    // random counts, both sides idling
    run_phase(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)),
              8'($urandom_range(1, 128)), 26, 26, 1'b0, 120);
    // register extremes (zero gives an all-ones edge), long receiver hold
    run_phase(8'd0, 8'd255, 8'd1, 0, 0, 1'b1, 120);
    // random counts again, light sender idling and heavy receiver stalling
    run_phase(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)),
              8'($urandom_range(1, 128)), 26, 63, 1'b0, 160);

    drain_queries();
    if (err_cnt == 0 && pending_nbr_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
